// ===== rtl/tkbs_pkg.sv =====
`timescale 1ns / 1ps

package tkbs_pkg;

    localparam int MAX_KEPT_DEF = 64;
    localparam int CAP_W        = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd50;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [19:0]        record_id;
        logic signed [31:0] max_value;
        logic signed [31:0] min_value;
        logic signed [31:0] mean_value;
        logic signed [31:0] spread;
    } t_in_item;

    typedef struct packed {
        logic [19:0]        out_id;
        logic signed [31:0] out_max;
        logic signed [31:0] out_min;
        logic signed [31:0] out_mean;
        logic signed [31:0] out_spread;
        logic               is_last;
        logic               list_empty;
    } t_out_item;

    typedef struct packed {
        logic [19:0]        id;
        logic signed [31:0] max_v;
        logic signed [31:0] min_v;
        logic signed [31:0] mean_v;
        logic signed [31:0] spread;
    } t_rec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PLACE,
        ST_DMP_RD,
        ST_DMP_OUT,
        ST_DMP_EMPTY
    } t_state;

    typedef struct packed {
        logic load_item;
        logic pos_from_count;
        logic pos_clear;
        logic pos_dec;
        logic pos_inc;
        logic rd_prev;
        logic wr_copy;
        logic wr_new;
        logic count_inc;
        logic out_load;
        logic out_empty;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic pos_one;
        logic pos_is_last;
        logic greater;
        logic pos_lt_cap;
        logic count_lt_cap;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/tkbs_ctrl.sv =====
`timescale 1ns / 1ps

module tkbs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_kind,
    output logic             o_in_ready,
    input  tkbs_pkg::t_sts   i_sts,
    output tkbs_pkg::t_cmd   o_cmd
);

    tkbs_pkg::t_state r_state;
    tkbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tkbs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    if (i_in_kind == tkbs_pkg::KIND_DUMP) begin
                        o_cmd.pos_clear = 1'b1;
                        n_state = i_sts.count_zero ? tkbs_pkg::ST_DMP_EMPTY
                                                   : tkbs_pkg::ST_DMP_RD;
                    end else begin
                        o_cmd.pos_from_count = 1'b1;
                        n_state = i_sts.count_zero ? tkbs_pkg::ST_INS_PLACE
                                                   : tkbs_pkg::ST_INS_RD;
                    end
                end
            end
            tkbs_pkg::ST_INS_RD: begin
                o_cmd.rd_prev = 1'b1;
                n_state = tkbs_pkg::ST_INS_CMP;
            end
            tkbs_pkg::ST_INS_CMP: begin
                o_cmd.rd_prev = 1'b1;
                if (i_sts.greater) begin
                    // Shift the smaller record down one slot; it falls off at capacity.
                    o_cmd.wr_copy = i_sts.pos_lt_cap;
                    o_cmd.pos_dec = 1'b1;
                    n_state = i_sts.pos_one ? tkbs_pkg::ST_INS_PLACE
                                            : tkbs_pkg::ST_INS_RD;
                end else begin
                    n_state = tkbs_pkg::ST_INS_PLACE;
                end
            end
            tkbs_pkg::ST_INS_PLACE: begin
                o_cmd.wr_new    = i_sts.pos_lt_cap;
                o_cmd.count_inc = i_sts.count_lt_cap;
                n_state = tkbs_pkg::ST_IDLE;
            end
            tkbs_pkg::ST_DMP_RD: begin
                n_state = tkbs_pkg::ST_DMP_OUT;
            end
            tkbs_pkg::ST_DMP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.pos_inc  = 1'b1;
                    n_state = i_sts.pos_is_last ? tkbs_pkg::ST_IDLE
                                                : tkbs_pkg::ST_DMP_RD;
                end
            end
            tkbs_pkg::ST_DMP_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.out_empty = 1'b1;
                    n_state = tkbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tkbs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tkbs_dp.sv =====
`timescale 1ns / 1ps

module tkbs_dp #(
    parameter int MAX_KEPT = tkbs_pkg::MAX_KEPT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tkbs_pkg::t_in_item           i_in_item,
    input  logic                         i_cfg_we,
    input  logic [tkbs_pkg::CAP_W-1:0]   i_cfg_data,
    input  tkbs_pkg::t_cmd               i_cmd,
    output tkbs_pkg::t_sts               o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tkbs_pkg::t_out_item          o_out_item
);

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);

    tkbs_pkg::t_rec mem [MAX_KEPT];

    tkbs_pkg::t_in_item            r_item;
    tkbs_pkg::t_rec                r_rd;
    logic [CW-1:0]                 r_pos;
    logic [CW-1:0]                 r_count;
    logic [tkbs_pkg::CAP_W-1:0]    r_cap;
    logic                          r_out_valid;
    tkbs_pkg::t_out_item           r_out_item;

    logic [tkbs_pkg::CAP_W-1:0]    cap_sat;
    logic [CW-1:0]                 eff_cap;
    logic [CW-1:0]                 pos_m1;
    logic [CW:0]                   pos_p1;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic                          wr_en;
    tkbs_pkg::t_rec                wr_data;
    tkbs_pkg::t_rec                new_rec;

    always_comb begin
        if (r_cap == '0) begin
            cap_sat = tkbs_pkg::CAP_W'(1);
        end else if (r_cap > tkbs_pkg::CAP_W'(MAX_KEPT)) begin
            cap_sat = tkbs_pkg::CAP_W'(MAX_KEPT);
        end else begin
            cap_sat = r_cap;
        end
    end
    assign eff_cap = cap_sat[CW-1:0];

    assign pos_m1  = r_pos - CW'(1);
    assign pos_p1  = {1'b0, r_pos} + (CW+1)'(1);
    // Insertion reads the slot above the hole; a dump reads the slot itself.
    assign rd_addr = i_cmd.rd_prev ? pos_m1[AW-1:0] : r_pos[AW-1:0];
    assign wr_addr = r_pos[AW-1:0];

    assign new_rec.id     = r_item.record_id;
    assign new_rec.max_v  = r_item.max_value;
    assign new_rec.min_v  = r_item.min_value;
    assign new_rec.mean_v = r_item.mean_value;
    assign new_rec.spread = r_item.spread;

    assign wr_en   = i_cmd.wr_copy | i_cmd.wr_new;
    assign wr_data = i_cmd.wr_new ? new_rec : r_rd;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_cap   <= tkbs_pkg::CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap   <= i_cfg_data;
                r_count <= '0;
            end else if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.pos_from_count) begin
                r_pos <= r_count;
            end else if (i_cmd.pos_clear) begin
                r_pos <= '0;
            end else if (i_cmd.pos_dec) begin
                r_pos <= pos_m1;
            end else if (i_cmd.pos_inc) begin
                r_pos <= pos_p1[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.out_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.out_id     <= r_rd.id;
            r_out_item.out_max    <= r_rd.max_v;
            r_out_item.out_min    <= r_rd.min_v;
            r_out_item.out_mean   <= r_rd.mean_v;
            r_out_item.out_spread <= r_rd.spread;
            r_out_item.is_last    <= (pos_p1 == {1'b0, r_count});
            r_out_item.list_empty <= 1'b0;
        end else if (i_cmd.out_empty) begin
            r_out_item <= '{list_empty: 1'b1, default: '0};
        end
    end

    assign o_sts.count_zero   = (r_count == '0);
    assign o_sts.pos_one      = (r_pos == CW'(1));
    assign o_sts.pos_is_last  = (pos_p1 == {1'b0, r_count});
    assign o_sts.greater      = (r_item.spread > r_rd.spread);
    assign o_sts.pos_lt_cap   = (r_pos < eff_cap);
    assign o_sts.count_lt_cap = (r_count < eff_cap);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/top_k_by_spread_list.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Signals                        Content
// input    in         i_in_valid/o_in_ready          t_in_item: insert or dump request
// output   out        o_out_valid/i_out_ready        t_out_item: one kept record per item
// config   in         i_cfg_we/i_cfg_data            capacity_in_use; a write clears the list
//
// Insert with n records kept: each record compared (at most n) is read, then compared.
// The walk is set by the registered read port of the record memory.
// Dump: each record is read, then loaded out; an empty list gives one empty-list item; a stalled output waits.
// Reset is synchronous; it empties the list and sets capacity to 50.
// The output register holds a finished item while the next request is taken.

module top_k_by_spread_list #(
    parameter int MAX_KEPT = tkbs_pkg::MAX_KEPT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tkbs_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tkbs_pkg::t_out_item          o_out_item,
    input  logic                         i_cfg_we,
    input  logic [tkbs_pkg::CAP_W-1:0]   i_cfg_data
);

    tkbs_pkg::t_cmd cmd;
    tkbs_pkg::t_sts sts;

    tkbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_item.kind),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tkbs_dp #(
        .MAX_KEPT (MAX_KEPT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/tkbs_checker.sv =====
`timescale 1ns / 1ps

module tkbs_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  tkbs_pkg::t_out_item   o_out_item
);

    // A stalled result item must hold its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // An accepted request always takes the controller out of ST_IDLE, so input ready drops.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on back-to-back cycles");

    // The empty-list result carries no record and no last mark.
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.list_empty |->
            !o_out_item.is_last && o_out_item.out_id == '0 && o_out_item.out_spread == '0)
        else $error("empty-list result carries data");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind top_k_by_spread_list tkbs_checker u_tkbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
